FILE: hdl/lzrd_pkg.sv
// lzrd_pkg: shared widths and constants of the lz/rle byte decompressor
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package lzrd_pkg;

    localparam int BYTE_W = 8;
    localparam int RUN_W  = 13;
    localparam int HI_W   = 5;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [RUN_W-1:0]  t_run;
    typedef logic [HI_W-1:0]   t_hi;

    localparam t_run CNT_BIAS = t_run'(4);

endpackage

`default_nettype wire

FILE: hdl/lzrd_ifs.sv
// lzrd_in_if / lzrd_out_if: valid/ready channels of the decompressor
// depends on lzrd_pkg for payload types
`default_nettype none

interface lzrd_in_if import lzrd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzrd_out_if import lzrd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte out_byte;
    t_run  run_length;
    logic  last;
    logic  stream_end;
    logic  bad_reference;

    modport source (output valid, output out_byte, output run_length, output last,
                    output stream_end, output bad_reference, input ready);
    modport sink   (input valid, input out_byte, input run_length, input last,
                    input stream_end, input bad_reference, output ready);
endinterface

`default_nettype wire

FILE: hdl/lz_rle_byte_decompressor_top.sv
// lz_rle_byte_decompressor_top: byte-serial lz/rle decompressor with history memory
// depends on lzrd_pkg and the channel interfaces in lzrd_ifs.sv
//
// usage
//   i_in_ch carries one compressed byte per request; o_out_ch carries result
//   requests (byte, run length, last, stream end, bad reference flag).
//   one small sequencer drives a single history port pair and the pointer and
//   count updates. a byte is taken into a holding register and then decoded.
//   each copied byte of a back-reference or follow-on goes through a registered
//   history read, then write and result. a repeat value byte gives its result at
//   decode and then writes history one byte a cycle (count 4 to 4099).
//   the input is not ready while a byte is being worked on.
//   results sit in one output register; the next input byte is taken while it
//   waits. when the receiver stalls, decode and copy steps hold until the
//   output register is free.
//   reset clears the parser, pointers and byte counter; history needs no clear
//   since read data is used only once its entry was written. the zero command byte
//   gives an end result and rearms the block the same way.
`default_nettype none

module lz_rle_byte_decompressor_top import lzrd_pkg::*; #(
    parameter int HISTORY_DEPTH = 8192
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lzrd_in_if.sink    i_in_ch,
    lzrd_out_if.source o_out_ch
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] PROD_MAX = PW'(HISTORY_DEPTH);

    localparam logic [2:0] PH_CMD       = 3'd0;
    localparam logic [2:0] PH_BACK_LOW  = 3'd1;
    localparam logic [2:0] PH_REP_LOW   = 3'd2;
    localparam logic [2:0] PH_REP_VALUE = 3'd3;
    localparam logic [2:0] PH_LIT_LOW   = 3'd4;
    localparam logic [2:0] PH_LIT_DATA  = 3'd5;

    localparam logic [2:0] S_IN   = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_FILL = 3'd4;

    // control state
    logic [2:0]    r_state, n_state;
    logic [2:0]    r_phase, n_phase;
    t_hi           r_hi, n_hi;
    t_run          r_cnt, n_cnt;
    logic [AW-1:0] r_cp, n_cp;
    logic [AW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_prod, n_prod;
    logic          r_after, n_after;
    logic          r_ok, n_ok;
    logic          r_out_valid, n_out_valid;

    // payload
    t_byte r_in, n_in;
    t_byte r_val, n_val;
    t_byte r_ob, n_ob;
    t_run  r_run, n_run;
    logic  r_last, n_last;
    logic  r_end, n_end;
    logic  r_bad, n_bad;

    // history memory
    t_byte         r_hist [HISTORY_DEPTH];
    t_byte         r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_byte         mem_wdata;

    logic          slot_free;
    logic [AW-1:0] gap;
    logic [AW-1:0] back_off;
    t_byte         copy_byte;
    logic          out_load;

    assign slot_free = !r_out_valid || o_out_ch.ready;
    assign gap       = r_wp - r_cp;
    assign back_off  = AW'({r_hi, r_in});
    assign copy_byte = r_ok ? r_rdata : '0;

    assign i_in_ch.ready          = (r_state == S_IN);
    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.out_byte      = r_ob;
    assign o_out_ch.run_length    = r_run;
    assign o_out_ch.last          = r_last;
    assign o_out_ch.stream_end    = r_end;
    assign o_out_ch.bad_reference = r_bad;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_hi        = r_hi;
        n_cnt       = r_cnt;
        n_cp        = r_cp;
        n_wp        = r_wp;
        n_prod      = r_prod;
        n_after     = r_after;
        n_ok        = r_ok;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        n_in        = r_in;
        n_val       = r_val;
        n_ob        = r_ob;
        n_run       = r_run;
        n_last      = r_last;
        n_end       = r_end;
        n_bad       = r_bad;
        mem_we      = 1'b0;
        mem_waddr   = r_wp;
        mem_wdata   = r_in;
        out_load    = 1'b0;

        unique case (r_state)
            S_IN: begin
                if (i_in_ch.valid) begin
                    n_in    = i_in_ch.in_byte;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (slot_free) begin
                    n_state = S_IN;
                    unique case (r_phase)
                        PH_BACK_LOW: begin
                            n_cp    = r_wp - back_off;
                            n_phase = PH_CMD;
                            n_after = 1'b1;
                            n_state = S_RD;
                        end
                        PH_REP_LOW: begin
                            n_cnt   = t_run'({r_hi[3:0], r_in}) + CNT_BIAS;
                            n_phase = PH_REP_VALUE;
                        end
                        PH_REP_VALUE: begin
                            n_val    = r_in;
                            out_load = 1'b1;
                            n_ob     = r_in;
                            n_run    = r_cnt;
                            n_last   = 1'b1;
                            n_end    = 1'b0;
                            n_bad    = 1'b0;
                            n_phase  = PH_CMD;
                            n_state  = S_FILL;
                        end
                        PH_LIT_LOW: begin
                            if ({r_hi, r_in} == '0) begin
                                n_phase = PH_CMD;
                            end else begin
                                n_cnt   = t_run'({r_hi, r_in});
                                n_phase = PH_LIT_DATA;
                            end
                        end
                        PH_LIT_DATA: begin
                            mem_we   = 1'b1;
                            n_wp     = r_wp + 1'b1;
                            if (r_prod != PROD_MAX) n_prod = r_prod + 1'b1;
                            out_load = 1'b1;
                            n_ob     = r_in;
                            n_run    = t_run'(1);
                            n_last   = 1'b1;
                            n_end    = 1'b0;
                            n_bad    = 1'b0;
                            n_cnt    = r_cnt - 1'b1;
                            if (r_cnt <= t_run'(1)) n_phase = PH_CMD;
                        end
                        default: begin
                            n_phase = PH_CMD;
                            if (r_after && r_in[7:5] == 3'b011) begin
                                if (r_in[4:0] != '0) begin
                                    n_cnt   = t_run'(r_in[4:0]);
                                    n_state = S_RD;
                                end
                            end else begin
                                n_after = 1'b0;
                                priority if (r_in[7]) begin
                                    n_hi    = r_in[4:0];
                                    n_cnt   = t_run'(r_in[6:5]) + CNT_BIAS;
                                    n_phase = PH_BACK_LOW;
                                end else if (r_in[6]) begin
                                    if (r_in[4]) begin
                                        n_hi    = {1'b0, r_in[3:0]};
                                        n_phase = PH_REP_LOW;
                                    end else begin
                                        n_cnt   = t_run'(r_in[3:0]) + CNT_BIAS;
                                        n_phase = PH_REP_VALUE;
                                    end
                                end else if (r_in[5]) begin
                                    n_hi    = r_in[4:0];
                                    n_phase = PH_LIT_LOW;
                                end else if (r_in == '0) begin
                                    n_hi     = '0;
                                    n_cnt    = '0;
                                    n_cp     = '0;
                                    n_wp     = '0;
                                    n_prod   = '0;
                                    out_load = 1'b1;
                                    n_ob     = '0;
                                    n_run    = '0;
                                    n_last   = 1'b1;
                                    n_end    = 1'b1;
                                    n_bad    = 1'b0;
                                end else begin
                                    n_cnt   = t_run'(r_in[4:0]);
                                    n_phase = PH_LIT_DATA;
                                end
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                n_ok    = (gap != '0) && ({1'b0, gap} <= r_prod);
                n_state = S_WR;
            end
            S_WR: begin
                if (slot_free) begin
                    mem_we    = 1'b1;
                    mem_wdata = copy_byte;
                    n_wp      = r_wp + 1'b1;
                    n_cp      = r_cp + 1'b1;
                    if (r_prod != PROD_MAX) n_prod = r_prod + 1'b1;
                    out_load  = 1'b1;
                    n_ob      = copy_byte;
                    n_run     = t_run'(1);
                    n_last    = (r_cnt == t_run'(1));
                    n_end     = 1'b0;
                    n_bad     = !r_ok;
                    n_cnt     = r_cnt - 1'b1;
                    n_state   = (r_cnt == t_run'(1)) ? S_IN : S_RD;
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = r_val;
                n_wp      = r_wp + 1'b1;
                if (r_prod != PROD_MAX) n_prod = r_prod + 1'b1;
                n_cnt     = r_cnt - 1'b1;
                if (r_cnt == t_run'(1)) n_state = S_IN;
            end
            default: begin
                n_state = S_IN;
            end
        endcase

        if (out_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IN;
            r_phase     <= PH_CMD;
            r_hi        <= '0;
            r_cnt       <= '0;
            r_cp        <= '0;
            r_wp        <= '0;
            r_prod      <= '0;
            r_after     <= 1'b0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_hi        <= n_hi;
            r_cnt       <= n_cnt;
            r_cp        <= n_cp;
            r_wp        <= n_wp;
            r_prod      <= n_prod;
            r_after     <= n_after;
            r_ok        <= n_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_val  <= n_val;
        r_ob   <= n_ob;
        r_run  <= n_run;
        r_last <= n_last;
        r_end  <= n_end;
        r_bad  <= n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_hist[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) r_rdata <= r_hist[r_cp];
    end

    // byte counter never passes the window size
    a_prod_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod <= PROD_MAX)
        else $error("byte counter beyond window");

    // copy and fill loops always have work left
    a_loop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_WR || r_state == S_FILL) |-> r_cnt != '0)
        else $error("loop running with zero count");

    // end result rearms pointers and counter
    a_end_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_end) |=> (r_wp == '0 && r_cp == '0 && r_prod == '0
                                 && r_phase == PH_CMD && !r_after))
        else $error("end request without rearm");

    // a bad reference result only leaves the write step
    a_bad_from_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_bad) |-> r_state == S_WR)
        else $error("bad reference outside copy");

    // output register is never overwritten while held
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> slot_free)
        else $error("result request lost");

endmodule

`default_nettype wire
